// ----- sv/terminal_key_sequence_decoder_defines.svh -----
// ---------------------------------------------------------------------------
// Terminal key sequence decoder: assertion macros
// Shared assertion forms. Each expects clk and rst in the enclosing module.
// ---------------------------------------------------------------------------
`ifndef TERMINAL_KEY_SEQUENCE_DECODER_DEFINES_SVH
`define TERMINAL_KEY_SEQUENCE_DECODER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TKSD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TKSD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Condition must hold at every clock edge outside reset.
`define TKSD_ASSERT_ALW(label, cond, msg) \
  `TKSD_ASSERT_IMP(label, 1'b1, cond, msg)

`endif

// ----- sv/tksd_pkg.sv -----
// ---------------------------------------------------------------------------
// Terminal key sequence decoder: package
// Event types, byte constants and the small decode tables.
// ---------------------------------------------------------------------------
package tksd_pkg;

  typedef enum logic [4:0] {
    EV_ESC       = 5'd0,
    EV_ENTER     = 5'd1,
    EV_TAB       = 5'd2,
    EV_BACKSPACE = 5'd3,
    EV_CHAR      = 5'd4,
    EV_UP        = 5'd5,
    EV_DOWN      = 5'd6,
    EV_RIGHT     = 5'd7,
    EV_LEFT      = 5'd8,
    EV_HOME      = 5'd9,
    EV_END       = 5'd10,
    EV_BACKTAB   = 5'd11,
    EV_INSERT    = 5'd12,
    EV_DELETE    = 5'd13,
    EV_PGUP      = 5'd14,
    EV_PGDN      = 5'd15,
    EV_FUNCTION  = 5'd16,
    EV_MOUSE     = 5'd17
  } event_code_t;

  typedef enum logic [2:0] {
    MK_PRESS      = 3'd0,
    MK_RELEASE    = 3'd1,
    MK_DRAG       = 3'd2,
    MK_WHEEL_UP   = 3'd3,
    MK_WHEEL_DOWN = 3'd4
  } mouse_kind_t;

  localparam int CHAR_W  = 7;
  localparam int FN_W    = 4;
  localparam int COORD_W = 17;

  typedef struct packed {
    event_code_t        code;
    logic [CHAR_W-1:0]  char_code;
    logic               ctrl;
    logic               shift;
    logic [FN_W-1:0]    fn;
    mouse_kind_t        mk;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } event_t;

  typedef struct packed {
    logic   valid;
    event_t ev;
  } decoded_t;

  // Up to two events produced by one byte, in order.
  typedef struct packed {
    logic [1:0] count;
    event_t     ev0;
    event_t     ev1;
  } push_t;

  typedef struct packed {
    event_t ev;
    logic   last;
  } queue_entry_t;

  localparam int QUEUE_DEPTH      = 8;
  localparam int QUEUE_PTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W      = QUEUE_PTR_W + 1;
  localparam int QUEUE_ROOM_LIMIT = QUEUE_DEPTH - 4;

  localparam logic [7:0] BYTE_BS     = 8'h08;
  localparam logic [7:0] BYTE_TAB    = 8'h09;
  localparam logic [7:0] BYTE_LF     = 8'h0A;
  localparam logic [7:0] BYTE_CR     = 8'h0D;
  localparam logic [7:0] BYTE_ESC    = 8'h1B;
  localparam logic [7:0] BYTE_SPACE  = 8'h20;
  localparam logic [7:0] BYTE_DIGIT0 = 8'h30;
  localparam logic [7:0] BYTE_DIGIT9 = 8'h39;
  localparam logic [7:0] BYTE_SEMI   = 8'h3B;
  localparam logic [7:0] BYTE_LT     = 8'h3C;
  localparam logic [7:0] BYTE_UP_A   = 8'h41;
  localparam logic [7:0] BYTE_UP_B   = 8'h42;
  localparam logic [7:0] BYTE_UP_C   = 8'h43;
  localparam logic [7:0] BYTE_UP_D   = 8'h44;
  localparam logic [7:0] BYTE_UP_F   = 8'h46;
  localparam logic [7:0] BYTE_UP_H   = 8'h48;
  localparam logic [7:0] BYTE_UP_M   = 8'h4D;
  localparam logic [7:0] BYTE_UP_O   = 8'h4F;
  localparam logic [7:0] BYTE_UP_P   = 8'h50;
  localparam logic [7:0] BYTE_UP_Q   = 8'h51;
  localparam logic [7:0] BYTE_UP_R   = 8'h52;
  localparam logic [7:0] BYTE_UP_S   = 8'h53;
  localparam logic [7:0] BYTE_UP_Z   = 8'h5A;
  localparam logic [7:0] BYTE_LBRACK = 8'h5B;
  localparam logic [7:0] BYTE_LO_A   = 8'h61;
  localparam logic [7:0] BYTE_LO_M   = 8'h6D;
  localparam logic [7:0] BYTE_LO_Z   = 8'h7A;
  localparam logic [7:0] BYTE_TILDE  = 8'h7E;
  localparam logic [7:0] BYTE_DEL    = 8'h7F;
  localparam logic [7:0] BYTE_HIGH   = 8'h80;

  localparam logic [CHAR_W-1:0] CTRL_CHAR_BASE = 7'h60;

  function automatic event_t make_event(event_code_t code);
    event_t ev;
    ev.code      = code;
    ev.char_code = '0;
    ev.ctrl      = 1'b0;
    ev.shift     = 1'b0;
    ev.fn        = '0;
    ev.mk        = MK_PRESS;
    ev.x         = '0;
    ev.y         = '0;
    return ev;
  endfunction

  // Decode of a byte seen with no sequence pending. ESC is handled by the caller.
  function automatic decoded_t ground_decode(logic [7:0] c);
    decoded_t d;
    d.valid = 1'b1;
    d.ev    = make_event(EV_CHAR);
    if (c == BYTE_CR || c == BYTE_LF) begin
      d.ev.code = EV_ENTER;
    end else if (c == BYTE_TAB) begin
      d.ev.code = EV_TAB;
    end else if (c == BYTE_DEL || c == BYTE_BS) begin
      d.ev.code = EV_BACKSPACE;
    end else if (c < BYTE_SPACE) begin
      d.ev.char_code = CTRL_CHAR_BASE + c[CHAR_W-1:0];
      d.ev.ctrl      = 1'b1;
    end else if (c < BYTE_HIGH) begin
      d.ev.char_code = c[CHAR_W-1:0];
    end else begin
      d.valid = 1'b0;
    end
    return d;
  endfunction

  // CSI final letters other than tilde.
  function automatic decoded_t letter_decode(logic [7:0] f);
    decoded_t d;
    d.valid = 1'b1;
    d.ev    = make_event(EV_UP);
    case (f)
      BYTE_UP_A: d.ev.code = EV_UP;
      BYTE_UP_B: d.ev.code = EV_DOWN;
      BYTE_UP_C: d.ev.code = EV_RIGHT;
      BYTE_UP_D: d.ev.code = EV_LEFT;
      BYTE_UP_H: d.ev.code = EV_HOME;
      BYTE_UP_F: d.ev.code = EV_END;
      BYTE_UP_Z: d.ev.code = EV_BACKTAB;
      default:   d.valid   = 1'b0;
    endcase
    return d;
  endfunction

  // Number before a tilde final, for numbers below 32.
  function automatic decoded_t tilde_decode(logic [4:0] p);
    decoded_t d;
    d.valid = 1'b1;
    d.ev    = make_event(EV_FUNCTION);
    case (p)
      5'd1, 5'd7:  d.ev.code = EV_HOME;
      5'd2:        d.ev.code = EV_INSERT;
      5'd3:        d.ev.code = EV_DELETE;
      5'd4, 5'd8:  d.ev.code = EV_END;
      5'd5:        d.ev.code = EV_PGUP;
      5'd6:        d.ev.code = EV_PGDN;
      5'd11, 5'd12, 5'd13, 5'd14:
        d.ev.fn = FN_W'(p - 5'd10);
      5'd15:       d.ev.fn = 4'd5;
      5'd17, 5'd18, 5'd19, 5'd20, 5'd21:
        d.ev.fn = FN_W'(p - 5'd11);
      5'd23, 5'd24:
        d.ev.fn = FN_W'(p - 5'd12);
      default:     d.valid = 1'b0;
    endcase
    return d;
  endfunction

  // Key byte after ESC O.
  function automatic decoded_t ss3_decode(logic [7:0] c);
    decoded_t d;
    d.valid = 1'b1;
    d.ev    = make_event(EV_FUNCTION);
    case (c)
      BYTE_UP_P: d.ev.fn   = 4'd1;
      BYTE_UP_Q: d.ev.fn   = 4'd2;
      BYTE_UP_R: d.ev.fn   = 4'd3;
      BYTE_UP_S: d.ev.fn   = 4'd4;
      BYTE_UP_H: d.ev.code = EV_HOME;
      BYTE_UP_F: d.ev.code = EV_END;
      default:   d.valid   = 1'b0;
    endcase
    return d;
  endfunction

endpackage

// ----- sv/tksd_parser.sv -----
// ---------------------------------------------------------------------------
// Terminal key sequence decoder: byte parser
// Holds the escape sequence state and turns one byte into up to two events.
// ---------------------------------------------------------------------------
`include "terminal_key_sequence_decoder_defines.svh"

module tksd_parser #(
  parameter int PARAM_BITS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            in_kind,
  input  logic [7:0]      in_byte,
  output tksd_pkg::push_t push
);

  typedef enum logic [1:0] {
    MODE_GROUND = 2'd0,
    MODE_ESC    = 2'd1,
    MODE_CSI    = 2'd2,
    MODE_SS3    = 2'd3
  } mode_t;

  localparam int ACC_W = PARAM_BITS + 4;

  mode_t                 mode_q, mode_next;
  logic                  angle_q, angle_next;
  logic                  at_start_q, at_start_next;
  logic                  started_q, started_next;
  logic [2:0]            field_count_q, field_count_next;
  logic [PARAM_BITS-1:0] field_value_q [3];
  logic [PARAM_BITS-1:0] field_value_next [3];
  logic [2:0]            field_bad_q, field_bad_next;

  logic [PARAM_BITS-1:0] fv [3];
  logic [PARAM_BITS-1:0] p0;
  logic [31:0]           x_wide, y_wide;
  logic [1:0]            idx;
  logic [ACC_W-1:0]      acc;
  logic                  is_final, is_digit, key_shift;
  tksd_pkg::decoded_t    dec;
  tksd_pkg::event_t      mouse_ev;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fv[i] = field_bad_q[i] ? '0 : field_value_q[i];
    end
    p0     = angle_q ? '0 : fv[0];
    x_wide = 32'(fv[1]);
    y_wide = 32'(fv[2]);
    idx    = 2'(field_count_q - 3'd1);
    acc    = (ACC_W'(field_value_q[idx]) << 3) + (ACC_W'(field_value_q[idx]) << 1)
           + ACC_W'(in_byte - tksd_pkg::BYTE_DIGIT0);
    is_digit = (in_byte >= tksd_pkg::BYTE_DIGIT0) && (in_byte <= tksd_pkg::BYTE_DIGIT9);
    is_final = (in_byte >= tksd_pkg::BYTE_UP_A && in_byte <= tksd_pkg::BYTE_UP_Z)
            || (in_byte >= tksd_pkg::BYTE_LO_A && in_byte <= tksd_pkg::BYTE_LO_Z)
            || (in_byte == tksd_pkg::BYTE_TILDE);
    key_shift = (field_count_q >= 3'd2) && (fv[1] == PARAM_BITS'(2) || fv[1] == PARAM_BITS'(6));

    // Mouse report: button bits select the kind, coordinates are one-based.
    mouse_ev       = tksd_pkg::make_event(tksd_pkg::EV_MOUSE);
    mouse_ev.shift = fv[0][2];
    mouse_ev.x     = x_wide[tksd_pkg::COORD_W-1:0] - tksd_pkg::COORD_W'(1);
    mouse_ev.y     = y_wide[tksd_pkg::COORD_W-1:0] - tksd_pkg::COORD_W'(1);
    if (fv[0][6]) begin
      mouse_ev.mk = fv[0][0] ? tksd_pkg::MK_WHEEL_DOWN : tksd_pkg::MK_WHEEL_UP;
    end else if (in_byte == tksd_pkg::BYTE_LO_M) begin
      mouse_ev.mk = tksd_pkg::MK_RELEASE;
    end else if (fv[0][5]) begin
      mouse_ev.mk = tksd_pkg::MK_DRAG;
    end else begin
      mouse_ev.mk = tksd_pkg::MK_PRESS;
    end

    mode_next        = mode_q;
    angle_next       = angle_q;
    at_start_next    = at_start_q;
    started_next     = started_q;
    field_count_next = field_count_q;
    field_value_next = field_value_q;
    field_bad_next   = field_bad_q;
    push.count       = 2'd0;
    push.ev0         = tksd_pkg::make_event(tksd_pkg::EV_ESC);
    push.ev1         = tksd_pkg::make_event(tksd_pkg::EV_CHAR);
    dec              = tksd_pkg::ground_decode(in_byte);

    if (in_valid && in_kind) begin
      // End of chunk flushes a lone ESC or ESC O.
      if (mode_q == MODE_ESC) begin
        push.count = 2'd1;
        mode_next  = MODE_GROUND;
      end else if (mode_q == MODE_SS3) begin
        push.count             = 2'd2;
        push.ev1.char_code     = tksd_pkg::BYTE_UP_O[tksd_pkg::CHAR_W-1:0];
        mode_next              = MODE_GROUND;
      end
    end else if (in_valid) begin
      case (mode_q)
        MODE_GROUND: begin
          if (in_byte == tksd_pkg::BYTE_ESC) begin
            mode_next = MODE_ESC;
          end else if (dec.valid) begin
            push.count = 2'd1;
            push.ev0   = dec.ev;
          end
        end
        MODE_ESC: begin
          if (in_byte == tksd_pkg::BYTE_LBRACK) begin
            mode_next = MODE_CSI;
            angle_next = 1'b0;
            at_start_next = 1'b1;
            started_next = 1'b0;
            field_count_next = 3'd1;
            for (int i = 0; i < 3; i++) begin
              field_value_next[i] = '0;
            end
            field_bad_next = 3'b111;
          end else if (in_byte == tksd_pkg::BYTE_UP_O) begin
            mode_next = MODE_SS3;
          end else if (in_byte == tksd_pkg::BYTE_ESC) begin
            // Escape is reported and a new sequence starts.
            push.count = 2'd1;
          end else begin
            mode_next  = MODE_GROUND;
            push.count = dec.valid ? 2'd2 : 2'd1;
            push.ev1   = dec.ev;
          end
        end
        MODE_CSI: begin
          if (is_final) begin
            if (angle_q && (in_byte == tksd_pkg::BYTE_UP_M ||
                            in_byte == tksd_pkg::BYTE_LO_M)) begin
              if (field_count_q == 3'd3) begin
                push.count = 2'd1;
                push.ev0   = mouse_ev;
              end
            end else begin
              if (in_byte == tksd_pkg::BYTE_TILDE) begin
                dec = tksd_pkg::tilde_decode(p0[4:0]);
                if (p0 >= PARAM_BITS'(32)) begin
                  dec.valid = 1'b0;
                end
              end else begin
                dec = tksd_pkg::letter_decode(in_byte);
              end
              dec.ev.shift = key_shift;
              if (dec.valid) begin
                push.count = 2'd1;
                push.ev0   = dec.ev;
              end
            end
            mode_next        = MODE_GROUND;
            angle_next       = 1'b0;
            at_start_next    = 1'b1;
            started_next     = 1'b0;
            field_count_next = 3'd1;
            for (int i = 0; i < 3; i++) begin
              field_value_next[i] = '0;
            end
            field_bad_next = 3'b111;
          end else if (at_start_q && in_byte == tksd_pkg::BYTE_LT) begin
            at_start_next = 1'b0;
            angle_next    = 1'b1;
          end else begin
            at_start_next = 1'b0;
            if (in_byte == tksd_pkg::BYTE_SEMI) begin
              if (field_count_q < 3'd4) begin
                field_count_next = field_count_q + 3'd1;
              end
              started_next = 1'b0;
            end else if (field_count_q <= 3'd3) begin
              // Bytes of fields past the third are ignored and not stored.
              if (is_digit) begin
                if (!started_q) begin
                  field_bad_next[idx] = 1'b0;
                end
                if (acc[ACC_W-1:PARAM_BITS] != '0) begin
                  field_bad_next[idx] = 1'b1;
                end else begin
                  field_value_next[idx] = acc[PARAM_BITS-1:0];
                end
              end else begin
                field_bad_next[idx] = 1'b1;
              end
              started_next = 1'b1;
            end
          end
        end
        MODE_SS3: begin
          mode_next = MODE_GROUND;
          dec       = tksd_pkg::ss3_decode(in_byte);
          if (dec.valid) begin
            push.count = 2'd1;
            push.ev0   = dec.ev;
          end
        end
        default: begin
          mode_next = MODE_GROUND;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_q        <= MODE_GROUND;
      angle_q       <= 1'b0;
      at_start_q    <= 1'b1;
      started_q     <= 1'b0;
      field_count_q <= 3'd1;
      for (int i = 0; i < 3; i++) begin
        field_value_q[i] <= '0;
      end
      field_bad_q   <= 3'b111;
    end else begin
      mode_q        <= mode_next;
      angle_q       <= angle_next;
      at_start_q    <= at_start_next;
      started_q     <= started_next;
      field_count_q <= field_count_next;
      field_value_q <= field_value_next;
      field_bad_q   <= field_bad_next;
    end
  end

  `TKSD_ASSERT_IMP(a_pair_starts_with_escape, push.count == 2'd2, push.ev0.code == tksd_pkg::EV_ESC, "two events without leading escape")
  `TKSD_ASSERT_NXT(a_chunk_end_flushes, in_valid && in_kind, mode_q != MODE_ESC && mode_q != MODE_SS3, "escape pending after chunk end")
  `TKSD_ASSERT_ALW(a_field_count_range, field_count_q >= 3'd1 && field_count_q <= 3'd4, "field count out of range")

endmodule

// ----- sv/tksd_queue.sv -----
// ---------------------------------------------------------------------------
// Terminal key sequence decoder: event queue
// Takes up to two events a cycle and hands them out one at a time.
// ---------------------------------------------------------------------------
module tksd_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  tksd_pkg::push_t        push,
  output logic                   room,
  output logic                   out_valid,
  input  logic                   out_ready,
  output tksd_pkg::queue_entry_t out_entry
);

  tksd_pkg::queue_entry_t          entries_q [tksd_pkg::QUEUE_DEPTH];
  logic [tksd_pkg::QUEUE_PTR_W-1:0] wr_ptr_q, rd_ptr_q, wr_ptr_second;
  logic [tksd_pkg::QUEUE_CNT_W-1:0] count_q, count_next;
  logic                            pop;

  assign out_valid     = (count_q != '0);
  assign out_entry     = entries_q[rd_ptr_q];
  assign pop           = out_valid && out_ready;
  assign room          = (count_q <= tksd_pkg::QUEUE_CNT_W'(tksd_pkg::QUEUE_ROOM_LIMIT));
  assign wr_ptr_second = wr_ptr_q + tksd_pkg::QUEUE_PTR_W'(1);
  assign count_next    = count_q + tksd_pkg::QUEUE_CNT_W'(push.count)
                       - tksd_pkg::QUEUE_CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries_q[wr_ptr_q] <= '{ev: push.ev0, last: (push.count == 2'd1)};
    end
    if (push.count == 2'd2) begin
      entries_q[wr_ptr_second] <= '{ev: push.ev1, last: 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + tksd_pkg::QUEUE_PTR_W'(push.count);
      rd_ptr_q <= rd_ptr_q + tksd_pkg::QUEUE_PTR_W'(pop);
      count_q  <= count_next;
    end
  end

endmodule

// ----- sv/terminal_key_sequence_decoder.sv -----
// ---------------------------------------------------------------------------
// Terminal key sequence decoder
// Turns a terminal byte stream into key and mouse events.
// ---------------------------------------------------------------------------
// The block takes one request per cycle while s_axis_tready is high: a
// terminal byte (tuser low) or an end-of-chunk marker (tuser high). Each
// request is registered, decoded in the following cycle against the escape
// sequence state, and the events it causes, zero, one or two, are written
// into an eight-entry event queue. Events pass the request register and the
// queue and leave it one per cycle while m_axis_tready is high; tlast marks
// the last event caused by a request. The input side stays ready while at
// least four queue entries are free, so a stream in which each byte causes
// at most one event runs at one byte per clock as long as the downstream
// side takes one event per clock; a byte that causes two events (an escape
// followed by a plain byte, or an end-of-chunk marker after ESC O) adds one
// more event to the output. CSI parameters are decimal fields of up to
// PARAM_BITS bits; a field that overflows or holds a non-digit reads as
// zero. Bytes 0x80 and above and unknown sequences produce no event, and a
// partial CSI sequence survives an end-of-chunk marker.
// ---------------------------------------------------------------------------
module terminal_key_sequence_decoder #(
  parameter int PARAM_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte
  input  logic [0:0]  s_axis_tuser,   // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // char_code[6:0], ctrl_flag, shift_flag, function_number[3:0],
  // mouse_kind[2:0], mouse_x[16:0], mouse_y[16:0], zero fill
  output logic [55:0] m_axis_tdata,
  output logic [4:0]  m_axis_tuser,   // event_code
  output logic        m_axis_tlast    // last_of_run
);

  // Registered request.
  logic       in_valid_q;
  logic       in_kind_q;
  logic [7:0] in_byte_q;

  tksd_pkg::push_t        push;
  tksd_pkg::queue_entry_t head;
  logic                   room;

  assign s_axis_tready = room;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= s_axis_tvalid && s_axis_tready;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_kind_q <= s_axis_tuser[0];
      in_byte_q <= s_axis_tdata;
    end
  end

  // Sequence state and decode; the queue entries act as the result register.
  tksd_parser #(
    .PARAM_BITS(PARAM_BITS)
  ) u_parser (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid_q),
    .in_kind  (in_kind_q),
    .in_byte  (in_byte_q),
    .push     (push)
  );

  tksd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_entry (head)
  );

  assign m_axis_tuser = head.ev.code;
  assign m_axis_tlast = head.last;
  assign m_axis_tdata = {6'b0, head.ev.y, head.ev.x, head.ev.mk, head.ev.fn,
                         head.ev.shift, head.ev.ctrl, head.ev.char_code};

endmodule
